### design/merge_sorter_top_assert.svh
// Assertion macros for the checker file ms_checker.sv.
`ifndef MERGE_SORTER_TOP_ASSERT_SVH
`define MERGE_SORTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ms_pkg.sv
package ms_pkg;

    localparam int MS_DATA_W    = 32;
    localparam int MS_MAX_ELEMS = 64;

    typedef struct packed {
        logic signed [MS_DATA_W-1:0] value;
        logic                        is_last;
    } ms_in_t;

    typedef struct packed {
        logic signed [MS_DATA_W-1:0] sorted_value;
        logic                        end_of_list;
    } ms_out_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_INIT,
        ST_PASS,
        ST_MERGE,
        ST_EMIT
    } ms_state_t;

    typedef struct packed {
        logic store;
        logic sort_init;
        logic run_init;
        logic merge_step;
        logic emit_init;
        logic emit_step;
    } ms_cmd_t;

    typedef struct packed {
        logic pass_end;
        logic sort_done;
        logic emit_last;
    } ms_stat_t;

endpackage

### design/merge_sorter_top.sv
// Merge sorter: collects a list of signed 32-bit values and returns it sorted.
//
// Input: raise start with an item (value, is_last) while busy is low; the
// item is taken at that clock edge. Items are stored in arrival order; once
// MAX_ELEMS are held, further values are dropped, but an item marked is_last
// still ends the list. After a non-final item, busy stays low for the next one.
// After the final item, busy stays high while the list is sorted by bottom-up
// merging between two ping-pong buffers, one element per cycle through a
// single compare unit: ceil(log2 n) passes are made over the n elements,
// each begun in a pass setup state, after an initial setup state for the sort.
// Results: strobe is high for exactly one cycle per sorted element, in
// ascending order with end_of_list on the last; they come back to back, one
// per cycle. The receiver cannot stall: sample on strobe.
// Reset clears the element count and the controller; the buffers are not
// cleared since only written entries are ever read.
module merge_sorter_top
    import ms_pkg::*;
#(
    parameter int MAX_ELEMS = MS_MAX_ELEMS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  ms_in_t  item,
    output logic    busy,
    output logic    strobe,
    output ms_out_t result
);

    // Command and status between sequencer and datapath.
    ms_cmd_t  cmd;
    ms_stat_t stat;

    // Sequencer: collect, set up each pass, merge, emit.
    ms_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (item.is_last),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Datapath: both buffers, run pointers, compare unit and output register.
    ms_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

endmodule

### design/ms_ctrl.sv
module ms_ctrl
    import ms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     is_last,
    input  ms_stat_t stat,
    output ms_cmd_t  cmd,
    output logic     busy
);

    ms_state_t state_reg;
    ms_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (start && is_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                state_next = stat.sort_done ? ST_EMIT : ST_MERGE;
            end
            ST_MERGE:
            begin
                if (stat.pass_end)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_EMIT:
            begin
                if (stat.emit_last)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_COLLECT:
            begin
                busy      = 1'b0;
                cmd.store = start;
            end
            ST_INIT:
            begin
                cmd.sort_init = 1'b1;
            end
            ST_PASS:
            begin
                cmd.emit_init = stat.sort_done;
                cmd.run_init  = !stat.sort_done;
            end
            ST_MERGE:
            begin
                cmd.merge_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### design/ms_datapath.sv
module ms_datapath
    import ms_pkg::*;
#(
    parameter int MAX_ELEMS = MS_MAX_ELEMS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  ms_in_t   item,
    input  ms_cmd_t  cmd,
    output ms_stat_t stat,
    output logic     strobe,
    output ms_out_t  result
);

    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam int AW = $clog2(MAX_ELEMS);
    localparam int DW = MS_DATA_W;

    logic [DW-1:0] mem0 [MAX_ELEMS];
    logic [DW-1:0] mem1 [MAX_ELEMS];

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic          strobe_reg, strobe_next;
    ms_out_t       result_reg, result_next;

    logic [DW-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;
    logic [DW-1:0] head_a, head_b, sel_data;
    logic          take_a;

    logic [SW-1:0] n_ext, w_ext, lo_adv, base, sum_mid, sum_hi;
    logic [CW-1:0] run_lo, run_mid, run_hi;
    logic [CW-1:0] k_inc, i_inc;
    logic          run_end, not_full;

    logic          wr0_en, wr1_en;
    logic [AW-1:0] wr0_addr;
    logic [DW-1:0] wr0_data;

    assign head_a = src_reg ? rd1a_reg : rd0a_reg;
    assign head_b = src_reg ? rd1b_reg : rd0b_reg;
    assign take_a = (i_reg < mid_reg)
                    && ((j_reg >= hi_reg) || ($signed(head_a) <= $signed(head_b)));
    assign sel_data = take_a ? head_a : head_b;

    // Bounds of the next run pair, clipped to the list length.
    assign n_ext   = SW'(cnt_reg);
    assign w_ext   = SW'(width_reg);
    assign lo_adv  = SW'(lo_reg) + (w_ext << 1);
    assign base    = cmd.run_init ? '0 : lo_adv;
    assign sum_mid = base + w_ext;
    assign sum_hi  = base + (w_ext << 1);
    assign run_lo  = base[CW-1:0];
    assign run_mid = (sum_mid > n_ext) ? cnt_reg : sum_mid[CW-1:0];
    assign run_hi  = (sum_hi > n_ext) ? cnt_reg : sum_hi[CW-1:0];

    assign k_inc    = k_reg + CW'(1);
    assign i_inc    = i_reg + CW'(1);
    assign run_end  = (k_inc == hi_reg);
    assign not_full = (cnt_reg < CW'(MAX_ELEMS));

    assign stat.pass_end  = run_end && (lo_adv >= n_ext);
    assign stat.sort_done = (width_reg >= WW'(cnt_reg));
    assign stat.emit_last = (i_inc == cnt_reg);

    always_comb
    begin
        cnt_next    = cnt_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        src_next    = src_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        if (cmd.store && not_full)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.sort_init)
        begin
            width_next = WW'(1);
            src_next   = 1'b0;
        end

        if (cmd.run_init)
        begin
            lo_next  = run_lo;
            mid_next = run_mid;
            hi_next  = run_hi;
            i_next   = run_lo;
            j_next   = run_mid;
            k_next   = run_lo;
        end

        if (cmd.merge_step)
        begin
            k_next = k_inc;
            if (take_a)
            begin
                i_next = i_inc;
            end
            else
            begin
                j_next = j_reg + CW'(1);
            end
            if (run_end)
            begin
                if (stat.pass_end)
                begin
                    // Pass complete: double the run width and swap buffers.
                    width_next = width_reg << 1;
                    src_next   = ~src_reg;
                end
                else
                begin
                    lo_next  = run_lo;
                    mid_next = run_mid;
                    hi_next  = run_hi;
                    i_next   = run_lo;
                    j_next   = run_mid;
                    k_next   = run_lo;
                end
            end
        end

        if (cmd.emit_init)
        begin
            i_next = '0;
        end

        if (cmd.emit_step)
        begin
            i_next                   = i_inc;
            strobe_next              = 1'b1;
            result_next.sorted_value = head_a;
            result_next.end_of_list  = stat.emit_last;
            if (stat.emit_last)
            begin
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            width_reg  <= '0;
            lo_reg     <= '0;
            mid_reg    <= '0;
            hi_reg     <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            src_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            width_reg  <= width_next;
            lo_reg     <= lo_next;
            mid_reg    <= mid_next;
            hi_reg     <= hi_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            src_reg    <= src_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign wr0_en   = (cmd.store && not_full) || (cmd.merge_step && src_reg);
    assign wr0_addr = cmd.store ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr0_data = cmd.store ? DW'(item.value) : sel_data;
    assign wr1_en   = cmd.merge_step && !src_reg;

    // Read at the next head positions so the registered data lines up.
    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            mem0[wr0_addr] <= wr0_data;
        end
        rd0a_reg <= mem0[i_next[AW-1:0]];
        rd0b_reg <= mem0[j_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr1_en)
        begin
            mem1[k_reg[AW-1:0]] <= sel_data;
        end
        rd1a_reg <= mem1[i_next[AW-1:0]];
        rd1b_reg <= mem1[j_next[AW-1:0]];
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

### design/ms_checker.sv
`include "merge_sorter_top_assert.svh"

module ms_checker
    import ms_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input ms_in_t  item,
    input logic    busy,
    input logic    strobe,
    input ms_out_t result
);

    `MS_ASSERT_SAME(a_mid_result_busy, strobe && !result.end_of_list, busy, "result before end while idle")
    `MS_ASSERT_NEXT(a_results_contiguous, strobe && !result.end_of_list, strobe, "gap in result stream")
    `MS_ASSERT_NEXT(a_single_end, strobe && result.end_of_list, !strobe, "result after end of list")
    `MS_ASSERT_NEXT(a_last_goes_busy, start && !busy && item.is_last, busy && !strobe, "list end not taken")
    `MS_ASSERT_NEXT(a_collect_stays, start && !busy && !item.is_last, !busy && !strobe, "busy while collecting")

endmodule

bind merge_sorter_top ms_checker u_ms_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

### verif/merge_sorter_checker.sv
module merge_sorter_checker
    import ms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  ms_in_t  item,
    input  logic    strobe,
    input  ms_out_t result,
    output int      mismatches,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Elements of the list being collected, kept in ascending order as they arrive.
    logic signed [MS_DATA_W-1:0] sorted_so_far[$];
    // Sorted elements of finished lists still owed by the block.
    ms_out_t                     expected_out[$];
    ms_out_t                     want;
    int                          slot;
    int                          k;
    int                          errs;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Check the result before taking new items, so that an expectation
            // made at this edge cannot cover a result from this edge.
            if (strobe)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d end_of_list %0b",
                           $signed(result.sorted_value), result.end_of_list);
                    errs++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (result.sorted_value !== want.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               $signed(want.sorted_value), $signed(result.sorted_value));
                        errs++;
                    end
                    if (result.end_of_list !== want.end_of_list)
                    begin
                        $error("end_of_list: expected %0b, got %0b",
                               want.end_of_list, result.end_of_list);
                        errs++;
                    end
                end
            end
            if (start && !busy)
            begin
                // Drop elements beyond capacity; insert after equal values.
                if (sorted_so_far.size() < MS_MAX_ELEMS)
                begin
                    slot = sorted_so_far.size();
                    while (slot > 0 && sorted_so_far[slot-1] > $signed(item.value))
                        slot--;
                    sorted_so_far.insert(slot, item.value);
                end
                if (item.is_last)
                begin
                    for (k = 0; k < sorted_so_far.size(); k++)
                        expected_out.push_back(ms_out_t'{
                            sorted_value: sorted_so_far[k],
                            end_of_list:  (k == sorted_so_far.size() - 1)});
                    sorted_so_far.delete();
                end
            end
        end
        mismatches <= errs;
        pending    <= expected_out.size();
    end

endmodule

### verif/merge_sorter_top_test.sv
module merge_sorter_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ms_pkg::*;

    typedef logic signed [MS_DATA_W-1:0] elem_t;

    localparam elem_t MOST_NEG = 32'h8000_0000;
    localparam elem_t MOST_POS = 32'h7fff_ffff;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    strobe;
    ms_in_t  item;
    ms_out_t result;
    int      mismatches;
    int      pending;

    // When set, the sender never idles between items.
    bit      calm;
    int      items_sent;
    int      lists_done;
    int      list_len;

    merge_sorter_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    merge_sorter_checker sort_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .strobe     (strobe),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses results.
    initial
    begin
        #400_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mix of extremes, a narrow band that forces duplicates, and full-range values.
    function automatic elem_t pick_value();
        case ($urandom_range(9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return elem_t'($urandom_range(8) - 4);
            default: return elem_t'($urandom);
        endcase
    endfunction

    // Present one item and hold it until the block takes it. Random idle
    // cycles go in front, with junk on the item bus while start is low.
    task automatic send_item(input elem_t v, input logic last);
        while (!calm && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            item  <= ms_in_t'{value: elem_t'($urandom), is_last: 1'($urandom_range(1))};
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= ms_in_t'{value: v, is_last: last};
        // busy read right after the edge is the value the block saw at that edge.
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send_list(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // Hold start low until every sorted element owed so far has come out.
    // pending lags the edge by one update, so step once before looking.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        calm       = 1'b0;
        items_sent = 0;
        lists_done = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element lists at both extremes.
        send_item(MOST_POS, 1'b1);
        send_item(MOST_NEG, 1'b1);
        // Extremes and values around zero: signed ordering.
        send_item(32'sd0, 1'b0);
        send_item(MOST_POS, 1'b0);
        send_item(MOST_NEG, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd1, 1'b1);
        // Two elements, out of order.
        send_item(32'sd7, 1'b0);
        send_item(-32'sd7, 1'b1);
        // Repeated values.
        send_item(32'sd3, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(-32'sd3, 1'b1);
        // Already in order.
        send_item(-32'sd2, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b1);
        // Reverse order, hugging both ends of the range.
        send_item(MOST_POS, 1'b0);
        send_item(MOST_POS - 1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(MOST_NEG + 1, 1'b0);
        send_item(MOST_NEG, 1'b1);

        // Let the block empty out completely before the random part.
        drain();

        // First an overlong list whose final, marked element is dropped, then
        // a list of exactly full capacity; after that mostly short lists
        // with the odd long one.
        while (items_sent < 420)
        begin
            if (lists_done == 0)
                list_len = MS_MAX_ELEMS + 6;
            else if (lists_done == 1)
                list_len = MS_MAX_ELEMS;
            else
            begin
                case ($urandom_range(99)) inside
                    [0:7]:   list_len = $urandom_range(MS_MAX_ELEMS + 6, MS_MAX_ELEMS - 4);
                    [8:14]:  list_len = 1;
                    default: list_len = $urandom_range(16, 2);
                endcase
            end
            // A stretch of lists sent with no idling between items.
            calm = (lists_done >= 12 && lists_done < 18);
            send_list(list_len);
            if ($urandom_range(9) == 0)
                drain();
            lists_done++;
        end

        drain();
        // Give a stray extra result time to show up.
        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
